>>> hdl/stp_pkg.sv
// Shared types, register indexes and color constants for the shape test-pattern pixel block.
`default_nettype none

package stp_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_SHAPE_SELECT = 2'd0;
   localparam logic [1:0] CSR_COLOR_Y      = 2'd1;
   localparam logic [1:0] CSR_COLOR_U      = 2'd2;
   localparam logic [1:0] CSR_COLOR_V      = 2'd3;

   // shape codes
   localparam logic [1:0] SHAPE_SQUARE   = 2'd0;
   localparam logic [1:0] SHAPE_CIRCLE   = 2'd1;
   localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;

   localparam logic [7:0] COLOR_RESET = 8'd128;

   // BT.601 integer coefficients
   localparam logic signed [9:0]  LUMA_OFFSET   = 10'sd16;
   localparam logic signed [9:0]  CHROMA_OFFSET = 10'sd128;
   localparam logic signed [18:0] K_Y           = 19'sd298;
   localparam logic signed [18:0] K_RV          = 19'sd409;
   localparam logic signed [18:0] K_GU          = 19'sd100;
   localparam logic signed [18:0] K_GV          = 19'sd208;
   localparam logic signed [18:0] K_BU          = 19'sd516;
   localparam logic signed [18:0] K_ROUND       = 19'sd128;
   localparam logic [7:0]         ALPHA_OPAQUE  = 8'hff;

   typedef struct packed {
      logic [1:0] shape_select;
      logic [7:0] color_y;
      logic [7:0] color_u;
      logic [7:0] color_v;
   } cfg_type;

   // floor(sum/256) clipped to 0..255
   function automatic logic [7:0] clip_channel(input logic signed [18:0] sum);
      logic [7:0] q;
      if (sum[18]) begin
         q = 8'd0;
      end else if (sum[17] || sum[16]) begin
         q = 8'd255;
      end else begin
         q = sum[15:8];
      end
      return q;
   endfunction

endpackage

`default_nettype wire

>>> hdl/stp_csr_regs.sv
// Configuration register file: shape select and fill color YUV.
`default_nettype none

module stp_csr_regs
   import stp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_en,
   input  wire logic [1:0] wr_index,
   input  wire logic [7:0] wr_data,
   output cfg_type         cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_SHAPE_SELECT: cfg_in.shape_select = wr_data[1:0];
            CSR_COLOR_Y:      cfg_in.color_y      = wr_data;
            CSR_COLOR_U:      cfg_in.color_u      = wr_data;
            CSR_COLOR_V:      cfg_in.color_v      = wr_data;
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.shape_select <= SHAPE_SQUARE;
         cfg_ff.color_y      <= COLOR_RESET;
         cfg_ff.color_u      <= COLOR_RESET;
         cfg_ff.color_v      <= COLOR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hdl/shape_test_pattern_pixel.sv
// Top level: four-stage pipeline that tests a pixel against a shape and fills it with a color.
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | column, row
//  rsp     | out       | rsp_valid/rsp_stall  | argb_pixel, inside_shape
//  csr     | in        | csr_valid/csr_ready  | index, write data
//
// One pixel per clock unless rsp_stall holds it; four register stages, so an accepted word
// moves through the input, stage 2, stage 3 and output registers before it shows on rsp.
// Stages: input register, offsets and color products, squares and color sums,
// compare and clip into the output register.
// Reset (synchronous) empties the pipeline and loads register defaults.
// A stalled stage holds; bubbles ahead of a stall are filled, so input keeps flowing.
`default_nettype none

module shape_test_pattern_pixel
   import stp_pkg::*;
#(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 256
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [8:0]  req_column,
   input  wire logic [7:0]  req_row,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [31:0] rsp_argb_pixel,
   output      logic        rsp_inside_shape,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);

   localparam int AW     = $clog2(FRAME_WIDTH + FRAME_HEIGHT + 1024);
   localparam int SW     = 2 * AW;
   localparam int DIM_I  = (FRAME_WIDTH < FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
   localparam int RAD_I  = DIM_I / 2;
   localparam int MID_I  = FRAME_WIDTH / 2;
   localparam int SQS_I  = (FRAME_WIDTH - DIM_I) / 2;

   localparam logic [AW-1:0] FW       = AW'(FRAME_WIDTH);
   localparam logic [AW-1:0] FH       = AW'(FRAME_HEIGHT);
   localparam logic [AW-1:0] DIM      = AW'(DIM_I);
   localparam logic [AW-1:0] RAD      = AW'(RAD_I);
   localparam logic [AW-1:0] RAD2     = AW'(2 * RAD_I);
   localparam logic [AW-1:0] MID      = AW'(MID_I);
   localparam logic [AW-1:0] SQ_START = AW'(SQS_I);
   localparam logic [AW-1:0] SQ_END   = AW'(SQS_I + DIM_I);
   localparam logic [SW:0]   RAD_SQ   = (SW + 1)'(RAD_I * RAD_I);

   cfg_type cfg;

   assign csr_ready = 1'b1;

   stp_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // ---------------- handshake / stage enables ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4      = !v4_ff || !rsp_stall;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: input word ----------------
   logic [8:0] col1_ff;
   logic [7:0] row1_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         col1_ff <= req_column;
         row1_ff <= req_row;
      end
   end

   logic [AW-1:0] col_x, row_x, grow, e_mag_in, n_mag_in;
   logic          in_frame, sq_hit_in, tri_hit_in, cir_row_in;
   logic signed [9:0]  cy, du, ev;
   logic signed [18:0] p_y_in, p_rv_in, p_gu_in, p_gv_in, p_bu_in;

   always_comb begin
      col_x    = AW'(col1_ff);
      row_x    = AW'(row1_ff);
      grow     = (row_x + 1'b1) >> 1;
      in_frame = (col_x < FW) && (row_x < FH);
      sq_hit_in  = in_frame && (row_x < DIM) && (col_x >= SQ_START) && (col_x < SQ_END);
      tri_hit_in = in_frame && (row_x < DIM) && ((col_x + grow) >= MID)
                   && (col_x <= (MID + grow));
      cir_row_in = in_frame && (row_x < RAD2);
      // distance from the center counted in whole pixels on each side
      e_mag_in = (col_x < MID) ? (MID - col_x) : (col_x - MID + 1'b1);
      n_mag_in = (row_x < RAD) ? (RAD - row_x) : (row_x - RAD);

      cy = signed'({2'b00, cfg.color_y}) - LUMA_OFFSET;
      du = signed'({2'b00, cfg.color_u}) - CHROMA_OFFSET;
      ev = signed'({2'b00, cfg.color_v}) - CHROMA_OFFSET;
      p_y_in  = 19'(cy) * K_Y;
      p_rv_in = 19'(ev) * K_RV;
      p_gu_in = 19'(du) * K_GU;
      p_gv_in = 19'(ev) * K_GV;
      p_bu_in = 19'(du) * K_BU;
   end

   // ---------------- stage 2: offsets and products ----------------
   logic [AW-1:0]      e2_ff, n2_ff;
   logic               sq2_ff, tri2_ff, cir2_ff;
   logic signed [18:0] p_y2_ff, p_rv2_ff, p_gu2_ff, p_gv2_ff, p_bu2_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         e2_ff    <= e_mag_in;
         n2_ff    <= n_mag_in;
         sq2_ff   <= sq_hit_in;
         tri2_ff  <= tri_hit_in;
         cir2_ff  <= cir_row_in;
         p_y2_ff  <= p_y_in;
         p_rv2_ff <= p_rv_in;
         p_gu2_ff <= p_gu_in;
         p_gv2_ff <= p_gv_in;
         p_bu2_ff <= p_bu_in;
      end
   end

   logic [SW-1:0]      esq_in, nsq_in;
   logic signed [18:0] sum_r_in, sum_g_in, sum_b_in;

   always_comb begin
      esq_in   = SW'(e2_ff) * SW'(e2_ff);
      nsq_in   = SW'(n2_ff) * SW'(n2_ff);
      sum_r_in = p_y2_ff + p_rv2_ff + K_ROUND;
      sum_g_in = p_y2_ff - p_gu2_ff - p_gv2_ff + K_ROUND;
      sum_b_in = p_y2_ff + p_bu2_ff + K_ROUND;
   end

   // ---------------- stage 3: squares and sums ----------------
   logic [SW-1:0]      esq3_ff, nsq3_ff;
   logic               sq3_ff, tri3_ff, cir3_ff;
   logic signed [18:0] sum_r3_ff, sum_g3_ff, sum_b3_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         esq3_ff   <= esq_in;
         nsq3_ff   <= nsq_in;
         sq3_ff    <= sq2_ff;
         tri3_ff   <= tri2_ff;
         cir3_ff   <= cir2_ff;
         sum_r3_ff <= sum_r_in;
         sum_g3_ff <= sum_g_in;
         sum_b3_ff <= sum_b_in;
      end
   end

   logic        cir_hit, hit_in;
   logic [31:0] pixel_in;

   always_comb begin
      cir_hit = cir3_ff && (({1'b0, esq3_ff} + {1'b0, nsq3_ff}) <= RAD_SQ);
      case (cfg.shape_select)
         SHAPE_SQUARE:   hit_in = sq3_ff;
         SHAPE_CIRCLE:   hit_in = cir_hit;
         SHAPE_TRIANGLE: hit_in = tri3_ff;
         default:        hit_in = 1'b0;
      endcase
      pixel_in = hit_in ? {ALPHA_OPAQUE, clip_channel(sum_r3_ff),
                           clip_channel(sum_g3_ff), clip_channel(sum_b3_ff)}
                        : 32'd0;
   end

   // ---------------- stage 4: output register ----------------
   logic [31:0] pixel4_ff;
   logic        hit4_ff;

   always_ff @(posedge clock) begin
      if (rdy4) begin
         pixel4_ff <= pixel_in;
         hit4_ff   <= hit_in;
      end
   end

   assign rsp_valid        = v4_ff;
   assign rsp_argb_pixel   = pixel4_ff;
   assign rsp_inside_shape = hit4_ff;

endmodule

`default_nettype wire

>>> tb/shape_pixel_checker.sv
// Checker: predicts the pixel word for each accepted request and compares it with the response.
module shape_pixel_checker
   import stp_pkg::*;
#(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 256
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [8:0]  req_column,
   input  logic [7:0]  req_row,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_argb_pixel,
   input  logic        rsp_inside_shape,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] argb_pixel;
      logic        inside_shape;
   } pixel_word_type;

   cfg_type        shadow_cfg;
   pixel_word_type expected_pixels[$];
   pixel_word_type oldest;
   int             mismatches = 0;

   // floor(sum/256) saturated to one byte
   function automatic logic [7:0] saturate_channel(int sum);
      int q;
      q = sum >>> 8;
      if (q < 0) return 8'd0;
      if (q > 255) return 8'd255;
      return q[7:0];
   endfunction

   function automatic logic [31:0] fill_argb(cfg_type cfg);
      int luma, cb, cr;
      logic [7:0] red, green, blue;
      luma  = int'(cfg.color_y) - 16;
      cb    = int'(cfg.color_u) - 128;
      cr    = int'(cfg.color_v) - 128;
      red   = saturate_channel(298 * luma + 409 * cr + 128);
      green = saturate_channel(298 * luma - 100 * cb - 208 * cr + 128);
      blue  = saturate_channel(298 * luma + 516 * cb + 128);
      return {ALPHA_OPAQUE, red, green, blue};
   endfunction

   function automatic bit pixel_covered(cfg_type cfg, int col, int row);
      int side, mid, start, rad, n, e, grow;
      side = (FRAME_WIDTH < FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
      mid  = FRAME_WIDTH / 2;
      if (col >= FRAME_WIDTH || row >= FRAME_HEIGHT) return 1'b0;
      case (cfg.shape_select)
         SHAPE_SQUARE: begin
            start = (FRAME_WIDTH - side) / 2;
            return row < side && col >= start && col < start + side;
         end
         SHAPE_CIRCLE: begin
            rad = side / 2;
            if (row >= 2 * rad) return 1'b0;
            n = row - rad;
            // distance in columns counts the center column pair as one step out
            e = (col < mid) ? (mid - col) : (col - mid + 1);
            return e * e + n * n <= rad * rad;
         end
         SHAPE_TRIANGLE: begin
            grow = (row + 1) / 2;
            return row < side && col >= mid - grow && col <= mid + grow;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic pixel_word_type predict_pixel(cfg_type cfg, logic [8:0] col,
                                                    logic [7:0] row);
      pixel_word_type word;
      if (pixel_covered(cfg, int'(col), int'(row))) begin
         word.argb_pixel   = fill_argb(cfg);
         word.inside_shape = 1'b1;
      end else begin
         word.argb_pixel   = 32'd0;
         word.inside_shape = 1'b0;
      end
      return word;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_cfg.shape_select <= SHAPE_SQUARE;
         shadow_cfg.color_y      <= COLOR_RESET;
         shadow_cfg.color_u      <= COLOR_RESET;
         shadow_cfg.color_v      <= COLOR_RESET;
         expected_pixels.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected response word: argb_pixel %h inside_shape %b",
                      rsp_argb_pixel, rsp_inside_shape);
               mismatches++;
            end else begin
               oldest = expected_pixels.pop_front();
               if (rsp_argb_pixel !== oldest.argb_pixel) begin
                  $error("argb_pixel mismatch: expected %h, got %h",
                         oldest.argb_pixel, rsp_argb_pixel);
                  mismatches++;
               end
               if (rsp_inside_shape !== oldest.inside_shape) begin
                  $error("inside_shape mismatch: expected %b, got %b",
                         oldest.inside_shape, rsp_inside_shape);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_pixels.push_back(predict_pixel(shadow_cfg, req_column, req_row));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SHAPE_SELECT: shadow_cfg.shape_select <= csr_wdata[1:0];
               CSR_COLOR_Y:      shadow_cfg.color_y      <= csr_wdata;
               CSR_COLOR_U:      shadow_cfg.color_u      <= csr_wdata;
               CSR_COLOR_V:      shadow_cfg.color_v      <= csr_wdata;
               default: ;
            endcase
         end
         pending_count <= expected_pixels.size();
      end
      error_count <= mismatches;
   end

endmodule

>>> tb/testbench.sv
// Testbench top: clock, reset, pixel and register stimulus, and the pass/fail verdict.
module testbench
   import stp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_WIDTH   = 320;
   localparam int FRAME_HEIGHT  = 256;
   localparam int PIPE_LATENCY  = 4;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS  = 125;
   localparam int CYCLE_LIMIT   = 200000;

   typedef enum logic [1:0] {
      STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_TOGGLE
   } stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [8:0]  req_column = '0;
   logic [7:0]  req_row = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_argb_pixel;
   logic        rsp_inside_shape;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   int             error_count;
   int             pending_count;
   int             cycle_count = 0;
   int             pixels_sent = 0;
   int             settings_run = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   shape_test_pattern_pixel #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .FRAME_HEIGHT(FRAME_HEIGHT)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_column      (req_column),
      .req_row         (req_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_argb_pixel  (rsp_argb_pixel),
      .rsp_inside_shape(rsp_inside_shape),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   shape_pixel_checker #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .FRAME_HEIGHT(FRAME_HEIGHT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_column      (req_column),
      .req_row         (req_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_argb_pixel  (rsp_argb_pixel),
      .rsp_inside_shape(rsp_inside_shape),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding",
                  cycle_count, pending_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver backpressure: mode is redrawn whenever the stall_left countdown runs out
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         stall_left <= $urandom_range(16, 160);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_RANDOM: rsp_stall <= ($urandom_range(0, 1) == 1);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 7) != 0);
         default:      rsp_stall <= ~rsp_stall;
      endcase
   end

   // leaves req_valid high; caller lowers it when the burst ends
   task automatic send_pixel(input logic [8:0] col, input logic [7:0] row);
      req_valid  <= 1'b1;
      req_column <= col;
      req_row    <= row;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // wait for every predicted word, then let the pipeline settle
   task automatic wait_idle();
      do @(posedge clock); while (pending_count != 0);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   // upper bits of the shape word are junk; only bits 1:0 matter
   task automatic load_setting(input logic [1:0] shape, input logic [7:0] y,
                               input logic [7:0] u, input logic [7:0] v, input bit all_regs);
      logic [5:0] junk;
      junk = 6'($urandom_range(0, 63));
      if (all_regs || $urandom_range(0, 3) != 0) write_csr(CSR_SHAPE_SELECT, {junk, shape});
      if (all_regs || $urandom_range(0, 3) != 0) write_csr(CSR_COLOR_Y, y);
      if (all_regs || $urandom_range(0, 3) != 0) write_csr(CSR_COLOR_U, u);
      if (all_regs || $urandom_range(0, 3) != 0) write_csr(CSR_COLOR_V, v);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_run++;
   endtask

   function automatic logic [7:0] pick_color();
      case ($urandom_range(0, 5))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      logic [8:0] edge_cols[6];
      logic [7:0] edge_rows[6];
      logic [1:0] shape;
      logic [7:0] cy, cu, cv;
      logic [8:0] col;
      logic [7:0] row;
      int         burst, gap, sent;

      // frame corner, far off-frame point, last column, first off-frame column, square/circle left edge, triangle apex
      edge_cols = '{9'd0, 9'd511, 9'd319, 9'd320, 9'd32, 9'd160};
      edge_rows = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd128, 8'd0};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset setting first, then each shape code including the unused one
      for (int s = 0; s < 4; s++) begin
         if (s != 0) begin
            load_setting(s[1:0], COLOR_RESET, COLOR_RESET, COLOR_RESET, 1'b1);
         end
         for (int k = 0; k < 6; k++) send_pixel(edge_cols[k], edge_rows[k]);
         req_valid <= 1'b0;
         wait_idle();
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin shape = SHAPE_SQUARE;   cy = 8'd0;   cu = 8'd0;   cv = 8'd0;   end
            1: begin shape = SHAPE_CIRCLE;   cy = 8'd255; cu = 8'd255; cv = 8'd255; end
            2: begin shape = SHAPE_TRIANGLE; cy = 8'd255; cu = 8'd0;   cv = 8'd255; end
            3: begin shape = SHAPE_SQUARE;   cy = 8'd16;  cu = 8'd255; cv = 8'd0;   end
            default: begin
               shape = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
               cy = pick_color();
               cu = pick_color();
               cv = pick_color();
            end
         endcase
         load_setting(shape, cy, cu, cv, p < 4);

         sent = 0;
         while (sent < PHASE_PIXELS) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < PHASE_PIXELS; b++) begin
               case ($urandom_range(0, 9))
                  0: col = 9'($urandom_range(FRAME_WIDTH, 511));
                  1: col = $urandom_range(0, 1) ? 9'($urandom_range(26, 38))
                                                : 9'($urandom_range(282, 294));
                  2: col = 9'($urandom_range(150, 170));
                  default: col = 9'($urandom_range(0, FRAME_WIDTH - 1));
               endcase
               row = 8'($urandom_range(0, 255));
               send_pixel(col, row);
               sent++;
            end
            case ($urandom_range(0, 7))
               0, 1, 2: gap = 0;
               3:       gap = $urandom_range(10, 30);
               default: gap = $urandom_range(1, 6);
            endcase
            if (sent < PHASE_PIXELS && gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         req_valid <= 1'b0;
         wait_idle();
      end

      repeat (PIPE_LATENCY + 4) @(posedge clock);
      $display("Sent %0d pixels under %0d register settings", pixels_sent, settings_run);
      $display("Shapes: square, circle, triangle and the unused code; colors at both extremes");
      if (error_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
